@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define SKF4_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("skf4 check failed");

// condition that must never be seen outside reset
`define SKF4_ASSERT_NEVER(name, expr) \
   name: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("skf4 forbidden condition seen");

`endif

@@ rtl/skf4_pkg.sv @@
// ---------------------------------------------------------------------------
// skf4_pkg
// Types and constants of the four-channel scalar Kalman filter core.
// ---------------------------------------------------------------------------
package skf4_pkg;

   localparam int CHANNEL_W   = 2;
   localparam int SAMPLE_W    = 16;
   localparam int DATA_W      = 32;
   localparam int GAIN_W      = 16;
   localparam int CSR_INDEX_W = 2;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_PROCESS_NOISE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEASURE_NOISE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_COV   = 2'd2;

   // reset values, unsigned Q16.16
   localparam logic [DATA_W-1:0] PROCESS_NOISE_RESET = 32'd66;
   localparam logic [DATA_W-1:0] MEASURE_NOISE_RESET = 32'd65536;
   localparam logic [DATA_W-1:0] INITIAL_COV_RESET   = 32'd65536000;

   // input transfer
   typedef struct packed {
      logic [CHANNEL_W-1:0]       channel;
      logic signed [SAMPLE_W-1:0] sample;
   } req_payload_type;

   // result transfer
   typedef struct packed {
      logic [CHANNEL_W-1:0]     out_channel;
      logic signed [DATA_W-1:0] estimate;
      logic [GAIN_W-1:0]        gain;
   } rsp_payload_type;

endpackage

@@ rtl/scalar_kalman_filter_4ch_core.sv @@
// ---------------------------------------------------------------------------
// scalar_kalman_filter_4ch_core
// One-dimensional Kalman filter for several channels, fixed point.
// ---------------------------------------------------------------------------
// Each sample runs the predict and update step of its channel: Pp = P + Q
// (saturating), gain K = Pp / (Pp + R) in Q0.16, estimate += K * (sample -
// estimate), P = (1 - K) * Pp. One item is worked on at a time, and the next
// transfer is taken when that one is done: the state memory is read on the
// transfer, the covariance is predicted, the restoring divider forms the gain
// (one quotient bit a cycle), the shared multiplier forms K * innovation and
// then (1 - K) * Pp, and the state is written back and the result register
// loaded. That last step waits for as long as an earlier result still sits
// unaccepted. A finished result waits in that register, and the next sample
// is taken while it waits. Channel state lives in one memory of estimate and
// covariance; per-entry valid bits stand for the reset values, so no clearing
// pass follows reset. Samples for a channel at or above CHANNELS return
// estimate 0 and gain 0, touch no state and skip the divider and the
// multiplier. The initial covariance register is accepted on the port but the
// covariance after reset is always its reset value.
// ---------------------------------------------------------------------------
module scalar_kalman_filter_4ch_core #(
   parameter int CHANNELS = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  skf4_pkg::req_payload_type            req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output skf4_pkg::rsp_payload_type            rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [skf4_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [skf4_pkg::DATA_W-1:0]          csr_wdata
);

   localparam int ADDR_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DIV_STEPS = 17;
   localparam int STEP_W    = $clog2(DIV_STEPS);
   localparam int DW        = skf4_pkg::DATA_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRED,
      ST_DIV,
      ST_MUL_EST,
      ST_MUL_COV,
      ST_WRITE
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [DW-1:0] q_ff, r_ff;

   // channel state memory: {estimate, covariance}
   logic [2*DW-1:0]   state_mem_ff [CHANNELS];
   logic [CHANNELS-1:0] vld_ff;
   logic [2*DW-1:0]   rd_data_ff;
   logic              rd_vld_ff;

   // item being worked on
   logic [ADDR_W-1:0]            addr_ff;
   logic [skf4_pkg::CHANNEL_W-1:0] chan_ff;
   logic                         in_range_ff;
   logic signed [skf4_pkg::SAMPLE_W-1:0] sample_ff;
   logic [DW-1:0]                est_ff, pp_ff;
   logic [DW:0]                  den_ff;
   logic [DW+1:0]                rem_ff;
   logic [DIV_STEPS-1:0]         dsh_ff, quo_ff;
   logic [STEP_W-1:0]            step_ff;
   logic [skf4_pkg::GAIN_W-1:0]  gain_ff;
   logic signed [51:0]           est_prod_ff, cov_prod_ff;

   logic                  rsp_valid_ff;
   skf4_pkg::rsp_payload_type rsp_data_ff;

   // input side
   logic                 req_fire;
   logic [ADDR_W+1:0]    chan_wide;
   logic [ADDR_W-1:0]    req_addr;
   logic                 req_in_range;

   assign req_ready    = (state_ff == ST_IDLE);
   assign req_fire     = req_valid && req_ready;
   assign chan_wide    = {{ADDR_W{1'b0}}, req_data.channel};
   assign req_addr     = chan_wide[ADDR_W-1:0];
   assign req_in_range = int'(req_data.channel) < CHANNELS;

   // prediction from the stored (or reset) state
   logic [DW-1:0] cur_est, cur_cov, pp_val;
   logic [DW:0]   pp_sum, den_val;

   assign cur_est = rd_vld_ff ? rd_data_ff[2*DW-1:DW] : '0;
   assign cur_cov = rd_vld_ff ? rd_data_ff[DW-1:0] : skf4_pkg::INITIAL_COV_RESET;
   assign pp_sum  = {1'b0, cur_cov} + {1'b0, q_ff};
   assign pp_val  = pp_sum[DW] ? '1 : pp_sum[DW-1:0];
   assign den_val = {1'b0, pp_val} + {1'b0, r_ff};

   // one restoring divider step
   logic [DW+1:0] trial, trial_sub;
   logic          trial_ge;

   assign trial     = {rem_ff[DW:0], dsh_ff[DIV_STEPS-1]};
   assign trial_ge  = trial >= {1'b0, den_ff};
   assign trial_sub = trial - {1'b0, den_ff};

   // gain from the quotient, zero denominator and saturation
   logic [skf4_pkg::GAIN_W-1:0] gain_val;

   always_comb begin
      if (den_ff == '0) begin
         gain_val = '0;
      end else if (quo_ff[DIV_STEPS-1]) begin
         gain_val = '1;
      end else begin
         gain_val = quo_ff[skf4_pkg::GAIN_W-1:0];
      end
   end

   // shared multiplier: K * innovation, then (1 - K) * Pp
   logic signed [DW:0]   innov;
   logic signed [17:0]   mul_a;
   logic signed [DW+1:0] mul_b;
   logic signed [51:0]   mul_p;
   logic [16:0]          one_minus_k;

   assign innov       = $signed({sample_ff[skf4_pkg::SAMPLE_W-1], sample_ff, 16'h0000})
                        - $signed({est_ff[DW-1], est_ff});
   assign one_minus_k = 17'h10000 - {1'b0, gain_ff};

   always_comb begin
      if (state_ff == ST_MUL_EST) begin
         mul_a = $signed({2'b00, gain_val});
         mul_b = $signed({innov[DW], innov});
      end else begin
         mul_a = $signed({1'b0, one_minus_k});
         mul_b = $signed({2'b00, pp_ff});
      end
   end

   assign mul_p = mul_a * mul_b;

   // update of the estimate, floor shift then clamp
   logic signed [DW+2:0] est_sum;
   logic [DW-1:0]        est_new, cov_new;

   assign est_sum = $signed({{3{est_ff[DW-1]}}, est_ff}) + $signed(est_prod_ff[50:16]);
   assign cov_new = cov_prod_ff[47:16];

   always_comb begin
      if (est_sum > $signed({3'b000, 32'h7FFF_FFFF})) begin
         est_new = 32'h7FFF_FFFF;
      end else if (est_sum < $signed({3'b111, 32'h8000_0000})) begin
         est_new = 32'h8000_0000;
      end else begin
         est_new = est_sum[DW-1:0];
      end
   end

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_fire) state_in = ST_PRED;
         ST_PRED:    state_in = in_range_ff ? ST_DIV : ST_WRITE;
         ST_DIV:     if (step_ff == STEP_W'(DIV_STEPS - 1)) state_in = ST_MUL_EST;
         ST_MUL_EST: state_in = ST_MUL_COV;
         ST_MUL_COV: state_in = ST_WRITE;
         ST_WRITE:   if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_WRITE && out_free) begin
            rsp_valid_ff            <= 1'b1;
            rsp_data_ff.out_channel <= chan_ff;
            rsp_data_ff.estimate    <= in_range_ff ? est_new : '0;
            rsp_data_ff.gain        <= in_range_ff ? gain_ff : '0;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // configuration writes; writes to the initial covariance are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= skf4_pkg::PROCESS_NOISE_RESET;
         r_ff <= skf4_pkg::MEASURE_NOISE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            skf4_pkg::CSR_PROCESS_NOISE: q_ff <= csr_wdata;
            skf4_pkg::CSR_MEASURE_NOISE: r_ff <= csr_wdata;
            skf4_pkg::CSR_INITIAL_COV:   ;
            default:                     ;
         endcase
      end
   end

   // valid bits of the state memory
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (state_ff == ST_WRITE && out_free && in_range_ff) begin
         vld_ff[addr_ff] <= 1'b1;
      end
   end

   // state memory: read on the input transfer, write back at the end of
   // the item; both never fall in the same cycle, so no forwarding is needed
   always_ff @(posedge clock) begin
      if (req_fire && req_in_range) begin
         rd_data_ff <= state_mem_ff[req_addr];
         rd_vld_ff  <= vld_ff[req_addr];
      end
      if (state_ff == ST_WRITE && out_free && in_range_ff) begin
         state_mem_ff[addr_ff] <= {est_new, cov_new};
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               addr_ff     <= req_addr;
               chan_ff     <= req_data.channel;
               in_range_ff <= req_in_range;
               sample_ff   <= req_data.sample;
            end
         end
         ST_PRED: begin
            pp_ff   <= pp_val;
            den_ff  <= den_val;
            est_ff  <= cur_est;
            rem_ff  <= {3'b000, pp_val[DW-1:1]};
            dsh_ff  <= {pp_val[0], 16'h0000};
            quo_ff  <= '0;
            step_ff <= '0;
         end
         ST_DIV: begin
            rem_ff  <= trial_ge ? trial_sub : trial;
            quo_ff  <= {quo_ff[DIV_STEPS-2:0], trial_ge};
            dsh_ff  <= {dsh_ff[DIV_STEPS-2:0], 1'b0};
            step_ff <= step_ff + 1'b1;
         end
         ST_MUL_EST: begin
            gain_ff     <= gain_val;
            est_prod_ff <= mul_p;
         end
         ST_MUL_COV: begin
            cov_prod_ff <= mul_p;
         end
         default: ;
      endcase
   end

endmodule

@@ rtl/skf4_checker.sv @@
// ---------------------------------------------------------------------------
// skf4_checker
// Port-level checks of the Kalman filter core, attached by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module skf4_port_checks #(
   parameter int CHANNELS = 4
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input skf4_pkg::rsp_payload_type rsp_data
);

   // result of a channel outside the filter carrying a non-zero field
   logic oob_nonzero;
   assign oob_nonzero = (int'(rsp_data.out_channel) >= CHANNELS)
                        && (rsp_data.estimate != '0 || rsp_data.gain != '0);

   // a stalled result stays and holds its value
   `SKF4_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))

   // one item at a time: no transfer right after a transfer
   `SKF4_ASSERT(a_one_in_flight, req_valid && req_ready |=> !req_ready)

   // a new result never follows its input transfer in the next cycle
   `SKF4_ASSERT(a_no_early_rsp, $rose(rsp_valid) |-> !$past(req_valid && req_ready))

   // channels outside the filter report zero estimate and gain
   `SKF4_ASSERT_NEVER(a_oob_zero, rsp_valid && oob_nonzero)

endmodule

bind scalar_kalman_filter_4ch_core skf4_port_checks #(
   .CHANNELS (CHANNELS)
) u_skf4_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
